// ----- hw/rtl/rlrs_pkg.sv -----
// Shared constants for the run-length row store.
// Field widths of the input, result and configuration words.
package rlrs_pkg;

  localparam int unsigned ROW_IN_W = 8;
  localparam int unsigned COL_W    = 12;
  localparam int unsigned VAL_W    = 13;
  localparam int unsigned HEIGHT_W = 9;

endpackage

// ----- hw/rtl/run_length_row_store_core.sv -----
// Run-length row store: binary image held per row as sorted run boundaries.
// Uses rlrs_pkg and two rlrs_ram instances (boundaries and per-row counts).
//
// One word is taken at a time. A word goes through the count read, the binary search
// over the n boundaries stored in the addressed row and the neighbor fetch. An in-place
// boundary update adds one write, a new pair adds two writes, and each boundary that an
// insert or erase moves goes through the single boundary RAM port as a read and a write.
// The input stalls until the word is finished. A finished result waits in the output
// register while the next word is accepted; a stalled output holds that next word in its
// final state until the result is taken. Counts are cleared at reset by per-row valid
// flags, so no clearing pass is needed.
module run_length_row_store_core
  import rlrs_pkg::*;
#(
  parameter int unsigned MAX_ROWS   = 256,
  parameter int unsigned MAX_EVENTS = 32,
  parameter int unsigned MAX_WIDTH  = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [HEIGHT_W-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                action,
  input  logic [ROW_IN_W-1:0] row,
  input  logic [COL_W-1:0]    col,
  input  logic [COL_W-1:0]    range_start,
  input  logic                pixel_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                pixel,
  output logic [VAL_W-1:0]    free_left,
  output logic                free_left_unbounded,
  output logic [VAL_W-1:0]    free_right,
  output logic                free_right_unbounded,
  output logic                any_in_range,
  output logic                changed,
  output logic                overflow
);

  localparam int unsigned ROW_W     = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned EV_W      = $clog2(MAX_EVENTS);
  localparam int unsigned CNT_W     = $clog2(MAX_EVENTS + 1);
  localparam int unsigned EV_DEPTH  = MAX_ROWS * MAX_EVENTS;
  localparam int unsigned EV_ADDR_W = EV_DEPTH > 1 ? $clog2(EV_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_CNT, S_SRCH, S_CMP, S_PREV, S_NEXT, S_DEC,
    S_MV_RD, S_MV_WR, S_PAIR0, S_PAIR1, S_SET, S_FIN
  } state_t;

  typedef enum logic [1:0] {OP_NONE, OP_INS, OP_ERA, OP_SET} op_t;

  state_t state;
  op_t    op;

  logic [HEIGHT_W-1:0] image_height;
  logic                act_q, val_q;
  logic [ROW_IN_W-1:0] row_q;
  logic [COL_W-1:0]    col_q, rs_q;
  logic                row_ok;
  logic [CNT_W-1:0]    n, lo, hi, mid, k, pos, j, n_new;
  logic [VAL_W-1:0]    ek1, set_val;
  logic [MAX_ROWS-1:0] cnt_vld;

  logic                r_pixel, r_flu, r_fru, r_any, r_chg, r_ovf;
  logic [VAL_W-1:0]    r_fl, r_fr;

  logic [CNT_W-1:0]    cnt_rdata;
  logic                cnt_we;
  logic [ROW_W-1:0]    cnt_raddr;
  logic [VAL_W-1:0]    ev_rdata, ev_wdata;
  logic                ev_we;
  logic [CNT_W-1:0]    ev_ridx, ev_widx;
  logic [EV_ADDR_W-1:0] ev_raddr, ev_waddr, row_base;

  logic [CNT_W:0]      mid_sum;
  logic [VAL_W-1:0]    col13, col_p1, ek;
  logic                need, wr_en, qry_ok;
  logic                fin_go;
  logic                d_pixel, d_flu, d_fru, d_any, d_chg, d_ovf;
  logic [VAL_W-1:0]    d_fl, d_fr, d_set_val;
  op_t                 d_op;
  logic [CNT_W-1:0]    d_pos, d_n_new, a_idx;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  assign fin_go    = (state == S_FIN) && (!out_valid || !out_stall);
  assign cnt_raddr = (state == S_IDLE) ? ROW_W'(row) : ROW_W'(row_q);
  assign cnt_we    = fin_go && r_chg;
  assign row_base  = EV_ADDR_W'(row_q) * EV_ADDR_W'(MAX_EVENTS);
  assign ev_raddr  = row_base + EV_ADDR_W'(ev_ridx[EV_W-1:0]);
  assign ev_waddr  = row_base + EV_ADDR_W'(ev_widx[EV_W-1:0]);

  rlrs_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ROWS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (ROW_W'(row_q)),
    .wdata (n_new),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  rlrs_ram #(.WIDTH(VAL_W), .DEPTH(EV_DEPTH)) u_ev_ram (
    .clk   (clk),
    .we    (ev_we),
    .waddr (ev_waddr),
    .wdata (ev_wdata),
    .raddr (ev_raddr),
    .rdata (ev_rdata)
  );

  assign mid_sum = {1'b0, lo} + {1'b0, hi};

  always_comb begin
    ev_ridx  = mid_sum[CNT_W:1];
    ev_widx  = pos;
    ev_we    = 1'b0;
    ev_wdata = ev_rdata;
    unique case (state)
      S_PREV:  ev_ridx = k - 1'b1;
      S_NEXT:  ev_ridx = k;
      S_MV_RD: ev_ridx = (op == OP_INS) ? j - 1'b1 : j;
      S_MV_WR: begin
        ev_we   = 1'b1;
        ev_widx = (op == OP_INS) ? j + 1'b1 : j - CNT_W'(2);
      end
      S_PAIR0: begin
        ev_we    = 1'b1;
        ev_wdata = col13;
      end
      S_PAIR1: begin
        ev_we    = 1'b1;
        ev_widx  = pos + 1'b1;
        ev_wdata = col_p1;
      end
      S_SET: begin
        ev_we    = 1'b1;
        ev_wdata = set_val;
      end
      default: ;
    endcase
  end

  // query results and write plan from k and the two neighbor boundaries
  assign col13  = VAL_W'(col_q);
  assign col_p1 = col13 + 1'b1;
  assign ek     = ev_rdata;
  assign need   = (32'(n) + 32'd2) > MAX_EVENTS;
  assign qry_ok = row_ok && (n != '0);
  assign wr_en  = act_q && row_ok && (32'(col_q) < MAX_WIDTH);
  assign a_idx  = k - 1'b1;

  always_comb begin
    d_pixel   = 1'b0;
    d_fl      = '0;
    d_flu     = 1'b1;
    d_fr      = '0;
    d_fru     = 1'b1;
    d_any     = 1'b0;
    if (qry_ok) begin
      d_pixel = k[0];
      if (k != '0) begin
        d_flu = 1'b0;
        d_fl  = k[0] ? col_p1 : ek1;
        d_any = k[0] || (ek1 > VAL_W'(rs_q));
      end
      if (k != n) begin
        d_fru = 1'b0;
        d_fr  = k[0] ? col13 : ek;
      end
    end
    d_op      = OP_NONE;
    d_pos     = '0;
    d_set_val = col13;
    d_ovf     = 1'b0;
    if (wr_en) begin
      priority if (n == '0) begin
        if (val_q) d_op = OP_INS;
      end else if (k == '0) begin
        if (val_q) begin
          if (ek > col_p1) d_op = OP_INS;
          else d_op = OP_SET;
        end
      end else if (k == n) begin
        if (val_q) begin
          if (ek1 == col13) begin
            d_op      = OP_SET;
            d_pos     = a_idx;
            d_set_val = col_p1;
          end else begin
            d_op  = OP_INS;
            d_pos = n;
          end
        end
      end else if (k[0] != val_q) begin
        priority if (ek - ek1 == VAL_W'(1)) begin
          d_op  = OP_ERA;
          d_pos = a_idx;
        end else if (col13 == ek1) begin
          d_op      = OP_SET;
          d_pos     = a_idx;
          d_set_val = col_p1;
        end else if (col_p1 == ek) begin
          d_op  = OP_SET;
          d_pos = k;
        end else begin
          d_op  = OP_INS;
          d_pos = k;
        end
      end
    end
    if (d_op == OP_INS && need) begin
      d_op  = OP_NONE;
      d_ovf = 1'b1;
    end
    d_chg   = (d_op != OP_NONE);
    d_n_new = (d_op == OP_INS) ? n + CNT_W'(2) :
              (d_op == OP_ERA) ? n - CNT_W'(2) : n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      image_height <= '0;
      cnt_vld      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) image_height <= cfg_data;
      if (fin_go) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            act_q <= action;
            row_q <= row;
            col_q <= col;
            rs_q  <= range_start;
            val_q <= pixel_value;
            row_ok <= (HEIGHT_W'(row) < image_height) && (32'(row) < MAX_ROWS);
            state <= S_CNT;
          end
        end
        S_CNT: begin
          n     <= cnt_vld[ROW_W'(row_q)] ? cnt_rdata : '0;
          lo    <= '0;
          hi    <= cnt_vld[ROW_W'(row_q)] ? cnt_rdata : '0;
          state <= S_SRCH;
        end
        S_SRCH: begin
          if (lo < hi) begin
            mid   <= mid_sum[CNT_W:1];
            state <= S_CMP;
          end else begin
            k     <= lo;
            state <= S_PREV;
          end
        end
        S_CMP: begin
          if (ev_rdata <= VAL_W'(col_q)) lo <= mid + 1'b1;
          else hi <= mid;
          state <= S_SRCH;
        end
        S_PREV: state <= S_NEXT;
        S_NEXT: begin
          ek1   <= ev_rdata;
          state <= S_DEC;
        end
        S_DEC: begin
          r_pixel <= d_pixel;
          r_fl    <= d_fl;
          r_flu   <= d_flu;
          r_fr    <= d_fr;
          r_fru   <= d_fru;
          r_any   <= d_any;
          r_chg   <= d_chg;
          r_ovf   <= d_ovf;
          op      <= d_op;
          pos     <= d_pos;
          set_val <= d_set_val;
          n_new   <= d_n_new;
          unique case (d_op)
            OP_INS: begin
              j     <= n;
              state <= (n > d_pos) ? S_MV_RD : S_PAIR0;
            end
            OP_ERA: begin
              j     <= d_pos + CNT_W'(2);
              state <= (d_pos + CNT_W'(2) < n) ? S_MV_RD : S_FIN;
            end
            OP_SET:  state <= S_SET;
            OP_NONE: state <= S_FIN;
          endcase
        end
        S_MV_RD: state <= S_MV_WR;
        S_MV_WR: begin
          if (op == OP_INS) begin
            j     <= j - 1'b1;
            state <= (j - 1'b1 > pos) ? S_MV_RD : S_PAIR0;
          end else begin
            j     <= j + 1'b1;
            state <= (j + 1'b1 < n) ? S_MV_RD : S_FIN;
          end
        end
        S_PAIR0: state <= S_PAIR1;
        S_PAIR1: state <= S_FIN;
        S_SET:   state <= S_FIN;
        S_FIN: begin
          if (fin_go) begin
            pixel                <= r_pixel;
            free_left            <= r_fl;
            free_left_unbounded  <= r_flu;
            free_right           <= r_fr;
            free_right_unbounded <= r_fru;
            any_in_range         <= r_any;
            changed              <= r_chg;
            overflow             <= r_ovf;
            if (r_chg) cnt_vld[ROW_W'(row_q)] <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_chg_ovf_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(changed && overflow))
    else $error("changed and overflow both set");

  a_set_bounded: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pixel) |-> (!free_left_unbounded && !free_right_unbounded))
    else $error("set pixel with unbounded zero run");

  a_cnt_even: assert property (@(posedge clk) disable iff (rst)
    cnt_we |-> (n_new[0] == 1'b0))
    else $error("odd boundary count written");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEC && d_ovf) |-> (d_op == OP_NONE && d_chg == 1'b0))
    else $error("refused write still planned");

endmodule

// ----- hw/rtl/rlrs_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rlrs_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench for run_length_row_store_core: random and directed pixel writes and queries.
// Depends on rlrs_pkg and the core; results are checked against an in-bench row store model.
`timescale 1ns / 100ps

module tb_top;
  import rlrs_pkg::*;

  localparam int unsigned N_ROWS   = 256;
  localparam int unsigned N_EVENTS = 32;
  localparam int unsigned N_WIDTH  = 4096;
  localparam int unsigned WATCHDOG = 20000;
  localparam int unsigned HOLD_LEN = 400;
  localparam logic ACT_QUERY = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef struct packed {
    logic                action;
    logic [ROW_IN_W-1:0] row;
    logic [COL_W-1:0]    col;
    logic [COL_W-1:0]    range_start;
    logic                pixel_value;
  } word_t;

  typedef struct packed {
    logic             pixel;
    logic [VAL_W-1:0] free_left;
    logic             free_left_unbounded;
    logic [VAL_W-1:0] free_right;
    logic             free_right_unbounded;
    logic             any_in_range;
    logic             changed;
    logic             overflow;
  } result_t;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [HEIGHT_W-1:0] cfg_data;
  logic in_valid, in_stall;
  word_t drv;
  logic out_valid, out_stall;
  logic got_pixel, got_flu, got_fru, got_any, got_chg, got_ovf;
  logic [VAL_W-1:0] got_fl, got_fr;
  result_t got;

  run_length_row_store_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(drv.action), .row(drv.row), .col(drv.col),
    .range_start(drv.range_start), .pixel_value(drv.pixel_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel(got_pixel), .free_left(got_fl),
    .free_left_unbounded(got_flu),
    .free_right(got_fr), .free_right_unbounded(got_fru),
    .any_in_range(got_any), .changed(got_chg), .overflow(got_ovf)
  );

  assign got = {got_pixel, got_fl, got_flu, got_fr, got_fru, got_any, got_chg, got_ovf};

  int unsigned bounds [N_ROWS][N_EVENTS];
  int unsigned nbounds [N_ROWS];
  int unsigned height;

  word_t   pending_words[$];
  result_t expected_results[$];
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  bit hold_req = 0;
  bit sender_pause = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic void queue_word(word_t w);
    pending_words.insert(pending_words.size(), w);
  endfunction

  function automatic int unsigned count_le(int unsigned r, int unsigned x);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = nbounds[r];
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (bounds[r][mid] <= x) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic void open_pair(int unsigned r, int unsigned pos, int unsigned i);
    int unsigned n;
    n = nbounds[r];
    for (int j = int'(n) - 1; j >= int'(pos); j--) bounds[r][j + 2] = bounds[r][j];
    bounds[r][pos] = i;
    bounds[r][pos + 1] = i + 1;
    nbounds[r] = n + 2;
  endfunction

  function automatic void close_pair(int unsigned r, int unsigned pos);
    int unsigned n;
    n = nbounds[r];
    for (int unsigned j = pos; j + 2 < n; j++) bounds[r][j] = bounds[r][j + 2];
    nbounds[r] = n - 2;
  endfunction

  // 0 unchanged, 1 changed, 2 refused
  function automatic int paint_pixel(int unsigned r, int unsigned i, bit v);
    int unsigned n, k, a;
    bit full;
    n = nbounds[r];
    full = (n + 2 > N_EVENTS);
    if (n == 0) begin
      if (!v) return 0;
      if (full) return 2;
      open_pair(r, 0, i);
      return 1;
    end
    k = count_le(r, i);
    if (k == 0) begin
      if (!v) return 0;
      if (bounds[r][0] > i + 1) begin
        if (full) return 2;
        open_pair(r, 0, i);
      end else bounds[r][0] = i;
      return 1;
    end
    if (k == n) begin
      if (!v) return 0;
      if (bounds[r][n - 1] == i) bounds[r][n - 1] = i + 1;
      else begin
        if (full) return 2;
        open_pair(r, n, i);
      end
      return 1;
    end
    a = k - 1;
    if ((a[0] == 1'b0) == v) return 0;
    if (bounds[r][a + 1] - bounds[r][a] == 1) close_pair(r, a);
    else if (i == bounds[r][a]) bounds[r][a] = i + 1;
    else if (i + 1 == bounds[r][a + 1]) bounds[r][a + 1] = i;
    else begin
      if (full) return 2;
      open_pair(r, a + 1, i);
    end
    return 1;
  endfunction

  function automatic result_t predict_row_access(word_t w);
    result_t e;
    int unsigned r, c, n, k, lim;
    bit ok;
    int res;
    r = w.row;
    c = w.col;
    lim = (height < N_ROWS) ? height : N_ROWS;
    ok = (r < lim);
    e = '0;
    e.free_left_unbounded = 1;
    e.free_right_unbounded = 1;
    if (ok && nbounds[r] != 0) begin
      n = nbounds[r];
      k = count_le(r, c);
      e.pixel = k[0];
      if (k != 0) begin
        e.free_left_unbounded = 0;
        e.free_left = k[0] ? VAL_W'(c + 1) : VAL_W'(bounds[r][k - 1]);
        e.any_in_range = k[0] || (bounds[r][k - 1] > w.range_start);
      end
      if (k != n) begin
        e.free_right_unbounded = 0;
        e.free_right = k[0] ? VAL_W'(c) : VAL_W'(bounds[r][k]);
      end
    end
    if (w.action == ACT_WRITE && ok && c < N_WIDTH) begin
      res = paint_pixel(r, c, w.pixel_value);
      e.changed = (res == 1);
      e.overflow = (res == 2);
    end
    return e;
  endfunction

  task automatic report(string what, int unsigned exp_v, int unsigned got_v);
    errors++;
    $display("mismatch %s: expected %0d got %0d (result %0d)", what, exp_v, got_v, results_seen);
  endtask

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  // capture handshake state at the rising edge for the driver
  logic in_stall_q;
  always @(posedge clk) begin
    in_stall_q <= in_stall;
    if (!rst && in_valid && !in_stall) begin
      expected_results.insert(expected_results.size(), predict_row_access(drv));
      words_sent++;
    end
  end

  // driver
  int unsigned in_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (in_valid && !in_stall_q) begin
      if (pending_words.size() != 0 && !sender_pause && in_gap == 0) begin
        drv <= pending_words.pop_front();
        in_valid <= 1;
        in_gap <= gap_len();
      end else begin
        in_valid <= 0;
      end
    end else if (!in_valid) begin
      if (in_gap != 0) in_gap <= in_gap - 1;
      else if (pending_words.size() != 0 && !sender_pause) begin
        drv <= pending_words.pop_front();
        in_valid <= 1;
        in_gap <= gap_len();
      end
    end
  end

  // receiver stall
  int unsigned out_gap = 0;
  int unsigned hold_cnt = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (hold_req) begin
      hold_req <= 0;
      hold_cnt <= HOLD_LEN;
      out_stall <= 1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1;
    end else if (out_gap != 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1;
    end else begin
      out_gap <= gap_len();
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("unexpected result %0d", results_seen);
      end else begin
        e = expected_results.pop_front();
        if (got.pixel !== e.pixel) report("pixel", e.pixel, got.pixel);
        if (got.free_left !== e.free_left) report("free_left", e.free_left, got.free_left);
        if (got.free_left_unbounded !== e.free_left_unbounded)
          report("free_left_unbounded", e.free_left_unbounded, got.free_left_unbounded);
        if (got.free_right !== e.free_right) report("free_right", e.free_right, got.free_right);
        if (got.free_right_unbounded !== e.free_right_unbounded)
          report("free_right_unbounded", e.free_right_unbounded, got.free_right_unbounded);
        if (got.any_in_range !== e.any_in_range)
          report("any_in_range", e.any_in_range, got.any_in_range);
        if (got.changed !== e.changed) report("changed", e.changed, got.changed);
        if (got.overflow !== e.overflow) report("overflow", e.overflow, got.overflow);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: nothing accepted for %0d cycles", WATCHDOG);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic word_t make_word(logic act, int unsigned r, int unsigned c,
                                      int unsigned rs, logic v);
    word_t w;
    w.action = act;
    w.row = ROW_IN_W'(r);
    w.col = COL_W'(c);
    w.range_start = COL_W'(rs);
    w.pixel_value = v;
    return w;
  endfunction

  function automatic word_t random_word(int unsigned hot_rows);
    int unsigned r, c, p;
    word_t w;
    p = $urandom_range(0, 99);
    r = (p < 85) ? $urandom_range(0, hot_rows - 1) : $urandom_range(0, 255);
    if ($urandom_range(0, 9) < 7) c = $urandom_range(0, 80);
    else c = $urandom_range(0, 4095);
    w = make_word($urandom_range(0, 99) < 65, r, c, 0, $urandom_range(0, 99) < 60);
    if ($urandom_range(0, 3) == 0) w.range_start = COL_W'($urandom_range(0, 4095));
    else w.range_start = (c > 10) ? COL_W'(c - $urandom_range(0, 10))
                                  : COL_W'($urandom_range(0, 12));
    return w;
  endfunction

  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_height(int unsigned h);
    @(negedge clk);
    cfg_data <= HEIGHT_W'(h);
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    height = h;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  initial begin
    int unsigned heights [5] = '{256, 3, 0, 200, 511};
    rst = 1;
    cfg_valid = 0;
    cfg_data = 0;
    out_stall = 0;
    in_valid = 0;
    drv = '0;
    height = 0;
    foreach (nbounds[i]) nbounds[i] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // height zero after reset: everything reads empty
    queue_word(make_word(ACT_WRITE, 0, 5, 0, 1));
    queue_word(make_word(ACT_QUERY, 0, 5, 0, 0));
    drain();
    write_height(256);
    queue_word(make_word(ACT_WRITE, 1, 0, 0, 1));
    queue_word(make_word(ACT_WRITE, 1, 4095, 0, 1));
    queue_word(make_word(ACT_WRITE, 1, 1, 0, 1));
    queue_word(make_word(ACT_WRITE, 1, 3, 0, 1));
    queue_word(make_word(ACT_WRITE, 1, 2, 0, 1));
    queue_word(make_word(ACT_WRITE, 1, 2, 0, 0));
    queue_word(make_word(ACT_WRITE, 1, 0, 0, 0));
    queue_word(make_word(ACT_WRITE, 1, 3, 0, 0));
    queue_word(make_word(ACT_WRITE, 1, 2, 0, 1));
    queue_word(make_word(ACT_WRITE, 1, 7, 0, 0));
    queue_word(make_word(ACT_QUERY, 1, 2, 4095, 0));
    queue_word(make_word(ACT_QUERY, 1, 4095, 0, 0));
    queue_word(make_word(ACT_QUERY, 1, 100, 50, 0));
    queue_word(make_word(ACT_QUERY, 255, 0, 0, 0));
    for (int i = 0; i < 17; i++)
      queue_word(make_word(ACT_WRITE, 2, 2 * i, 0, 1));
    queue_word(make_word(ACT_WRITE, 2, 2, 0, 0));
    queue_word(make_word(ACT_WRITE, 2, 1, 0, 1));
    drain();

    foreach (heights[h]) begin
      write_height(heights[h]);
      for (int i = 0; i < 320; i++) begin
        queue_word(random_word(h == 1 ? 5 : 8));
        if (i == 150 && h == 0) begin
          hold_req = 1;
          wait (hold_cnt != 0);
          wait (hold_cnt == 0);
        end
        if (i == 200 && h == 3) begin
          while (pending_words.size() != 0 || in_valid) @(posedge clk);
          sender_pause = 1;
          while (expected_results.size() != 0) @(posedge clk);
          sender_pause = 0;
        end
      end
      drain();
    end

    $display("covered %0d words and %0d results over %0d heights, incl. full rows",
             words_sent, results_seen, 6);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
